>>> hw/rtl/websocket_frame_deframer_core_assert.svh
// assertion macros used by the deframer core
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define WSFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define WSFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg
// Types and constants of the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsfd_pkg;

   // length width the hardware is specified for
   localparam int LENGTH_BITS = 64;
   // held length width: the configured maximum is 32 bits wide
   localparam int LEN_REG_BITS = 32;
   localparam logic [LEN_REG_BITS-1:0] MAX_LEN_RESET = 32'd65536;

   // header opcodes
   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   // 7-bit length codes
   localparam logic [6:0] LEN7_MAX   = 7'd125;
   localparam logic [6:0] LEN7_EXT16 = 7'd126;

   // byte counts of the header sections
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] MASK_BYTES  = 4'd4;

   // frame actions
   localparam logic [1:0] ACT_DELIVER = 2'd0;
   localparam logic [1:0] ACT_CLOSE   = 2'd1;
   localparam logic [1:0] ACT_IGNORE  = 2'd2;

   typedef enum logic [2:0] {
      PH_HDR1    = 3'd0,
      PH_HDR2    = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_MASK    = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // one parse step's result
   typedef struct packed {
      logic       emit;
      kind_type   kind;
      logic [7:0] payload_byte;
      logic [3:0] opcode;
      logic       fin;
      logic       last;
      logic [1:0] action;
   } step_type;

   // parser status seen by the top level
   typedef struct packed {
      logic      err_latched;
      phase_type phase;
   } status_type;

endpackage

>>> hw/rtl/wsfd_req_if.sv
// ----------------------------------------------------------------------------
// wsfd_req_if
// Received byte channel of the deframer.
// ----------------------------------------------------------------------------
interface wsfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

>>> hw/rtl/wsfd_rsp_if.sv
// ----------------------------------------------------------------------------
// wsfd_rsp_if
// Result channel of the deframer.
// ----------------------------------------------------------------------------
interface wsfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] payload_byte;
   logic [3:0] frame_opcode;
   logic       final_fragment;
   logic       last_of_frame;
   logic [1:0] frame_action;

   modport source (
      output valid, output result_kind, output payload_byte, output frame_opcode,
      output final_fragment, output last_of_frame, output frame_action,
      input ready
   );
   modport sink (
      input valid, input result_kind, input payload_byte, input frame_opcode,
      input final_fragment, input last_of_frame, input frame_action,
      output ready
   );
endinterface

>>> hw/rtl/wsfd_parser.sv
// ----------------------------------------------------------------------------
// wsfd_parser
// Frame parse state and the per-byte step: header checks, length, mask, unmask.
// ----------------------------------------------------------------------------
module wsfd_parser (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [7:0]                           data_byte,
   input  logic [wsfd_pkg::LEN_REG_BITS-1:0]    max_len,
   output wsfd_pkg::step_type                   step,
   output wsfd_pkg::status_type                 status
);

   localparam int LenKeep =
      (wsfd_pkg::LENGTH_BITS < wsfd_pkg::LEN_REG_BITS) ?
      wsfd_pkg::LENGTH_BITS : wsfd_pkg::LEN_REG_BITS;

   wsfd_pkg::phase_type                 phase_ff, phase_in;
   logic                                fin_ff, fin_in;
   logic [3:0]                          opcode_ff, opcode_in;
   logic [3:0]                          cnt_ff, cnt_in;
   logic [wsfd_pkg::LEN_REG_BITS-1:0]   len_ff, len_in;
   logic                                high_ff, high_in;
   logic [1:0]                          pos_ff, pos_in;
   logic                                err_ff, err_in;
   logic [7:0]                          mask_key_ff [4];
   logic                                mask_we;
   logic [1:0]                          mask_widx;
   logic                                fail;
   logic [1:0]                          action;

   // length check: no bits above the held width, fits, not above the maximum
   function automatic logic len_ok(
      input logic                              high,
      input logic [wsfd_pkg::LEN_REG_BITS-1:0] len,
      input logic [wsfd_pkg::LEN_REG_BITS-1:0] max
   );
      logic fits;
      fits = ((len >> LenKeep) == '0);
      return !high && fits && (len <= max);
   endfunction

   // action of the frame being finished
   always_comb begin
      if (fin_ff && (opcode_ff == wsfd_pkg::OP_TEXT || opcode_ff == wsfd_pkg::OP_BINARY)) begin
         action = wsfd_pkg::ACT_DELIVER;
      end else if (fin_ff && opcode_ff == wsfd_pkg::OP_CLOSE) begin
         action = wsfd_pkg::ACT_CLOSE;
      end else begin
         action = wsfd_pkg::ACT_IGNORE;
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= wsfd_pkg::PH_HDR1;
         fin_ff    <= 1'b0;
         opcode_ff <= '0;
         cnt_ff    <= '0;
         len_ff    <= '0;
         high_ff   <= 1'b0;
         pos_ff    <= '0;
         err_ff    <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         fin_ff    <= fin_in;
         opcode_ff <= opcode_in;
         cnt_ff    <= cnt_in;
         len_ff    <= len_in;
         high_ff   <= high_in;
         pos_ff    <= pos_in;
         err_ff    <= err_in;
      end
   end

   // mask key store
   always_ff @(posedge clock) begin
      if (mask_we) begin
         mask_key_ff[mask_widx] <= data_byte;
      end
   end

   // next state and step result
   always_comb begin
      phase_in  = phase_ff;
      fin_in    = fin_ff;
      opcode_in = opcode_ff;
      cnt_in    = cnt_ff;
      len_in    = len_ff;
      high_in   = high_ff;
      pos_in    = pos_ff;
      err_in    = err_ff;
      mask_we   = 1'b0;
      mask_widx = 2'd0 - cnt_ff[1:0];
      fail      = 1'b0;
      step      = '0;
      step.kind   = wsfd_pkg::KIND_DATA;
      step.opcode = opcode_ff;
      step.fin    = fin_ff;

      if (accept && !err_ff) begin
         case (phase_ff)
            wsfd_pkg::PH_HDR1: begin
               opcode_in   = data_byte[3:0];
               step.opcode = data_byte[3:0];
               if (data_byte[6:4] != 3'd0) begin
                  fail = 1'b1;
               end else begin
                  fin_in   = data_byte[7];
                  step.fin = data_byte[7];
                  if (!(data_byte[3:0] inside {wsfd_pkg::OP_CONT, wsfd_pkg::OP_TEXT,
                        wsfd_pkg::OP_BINARY, wsfd_pkg::OP_CLOSE, wsfd_pkg::OP_PING,
                        wsfd_pkg::OP_PONG})) begin
                     fail = 1'b1;
                  end else if (!data_byte[7] && data_byte[3]) begin
                     // fragmented control frame
                     fail = 1'b1;
                  end else begin
                     phase_in = wsfd_pkg::PH_HDR2;
                  end
               end
            end
            wsfd_pkg::PH_HDR2: begin
               high_in = 1'b0;
               len_in  = '0;
               if (!data_byte[7]) begin
                  fail = 1'b1;
               end else if (data_byte[6:0] <= wsfd_pkg::LEN7_MAX) begin
                  len_in = wsfd_pkg::LEN_REG_BITS'(data_byte[6:0]);
                  if (!len_ok(1'b0, len_in, max_len)) begin
                     fail = 1'b1;
                  end else begin
                     cnt_in   = wsfd_pkg::MASK_BYTES;
                     phase_in = wsfd_pkg::PH_MASK;
                  end
               end else begin
                  cnt_in   = (data_byte[6:0] == wsfd_pkg::LEN7_EXT16) ?
                             wsfd_pkg::EXT16_BYTES : wsfd_pkg::EXT64_BYTES;
                  phase_in = wsfd_pkg::PH_EXTLEN;
               end
            end
            wsfd_pkg::PH_EXTLEN: begin
               // big-endian shift; bits pushed out of the held width go sticky
               len_in  = {len_ff[wsfd_pkg::LEN_REG_BITS-9:0], data_byte};
               high_in = high_ff || (len_ff[wsfd_pkg::LEN_REG_BITS-1 -: 8] != 8'd0);
               cnt_in  = cnt_ff - 4'd1;
               if (cnt_in == 4'd0) begin
                  if (!len_ok(high_in, len_in, max_len)) begin
                     fail = 1'b1;
                  end else begin
                     cnt_in   = wsfd_pkg::MASK_BYTES;
                     phase_in = wsfd_pkg::PH_MASK;
                  end
               end
            end
            wsfd_pkg::PH_MASK: begin
               mask_we = 1'b1;
               cnt_in  = cnt_ff - 4'd1;
               if (cnt_in == 4'd0) begin
                  pos_in = '0;
                  if (len_ff == '0) begin
                     phase_in    = wsfd_pkg::PH_HDR1;
                     step.emit   = 1'b1;
                     step.kind   = wsfd_pkg::KIND_EMPTY;
                     step.last   = 1'b1;
                     step.action = action;
                  end else begin
                     phase_in = wsfd_pkg::PH_PAYLOAD;
                  end
               end
            end
            wsfd_pkg::PH_PAYLOAD: begin
               // len_ff counts the payload bytes still to come
               pos_in            = pos_ff + 2'd1;
               len_in            = len_ff - wsfd_pkg::LEN_REG_BITS'(1);
               step.emit         = 1'b1;
               step.kind         = wsfd_pkg::KIND_DATA;
               step.payload_byte = data_byte ^ mask_key_ff[pos_ff];
               if (len_ff == wsfd_pkg::LEN_REG_BITS'(1)) begin
                  phase_in    = wsfd_pkg::PH_HDR1;
                  step.last   = 1'b1;
                  step.action = action;
               end
            end
            default: begin
               phase_in = wsfd_pkg::PH_HDR1;
            end
         endcase

         // protocol error: one error result, then silence until reset
         if (fail) begin
            err_in       = 1'b1;
            step.emit    = 1'b1;
            step.kind    = wsfd_pkg::KIND_ERROR;
            step.last    = 1'b0;
            step.action  = wsfd_pkg::ACT_DELIVER;
         end
      end
   end

   assign status.err_latched = err_ff;
   assign status.phase       = phase_ff;

endmodule

>>> hw/rtl/websocket_frame_deframer_core.sv
// A result is registered: it is on rsp_bus in the cycle after the transfer of the byte that causes it.
// Throughput: one byte per cycle; a new byte is taken in the cycle a held result is taken.
// The only stall is a held result register whose content is not taken.
// Reset clears the parse state, the sticky error and max_payload_length (to 65536).
// The mask key store is not reset; every key byte is written before use.
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core
// Client-to-server frame deframer: header checks, length, unmasking per byte.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_core_assert.svh"

module websocket_frame_deframer_core (
   input  logic                              clock,
   input  logic                              reset,
   wsfd_req_if.sink                          req_bus,
   wsfd_rsp_if.source                        rsp_bus,
   input  logic                              csr_wr_en,
   input  logic [wsfd_pkg::LEN_REG_BITS-1:0] csr_wr_data
);

   logic [wsfd_pkg::LEN_REG_BITS-1:0] max_len_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   wsfd_pkg::step_type                rsp_ff;
   wsfd_pkg::step_type                step;
   wsfd_pkg::status_type              status;
   logic                              req_fire;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= wsfd_pkg::MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   // input side is ready whenever the result register frees up this cycle
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;

   wsfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_fire),
      .data_byte (req_bus.data_byte),
      .max_len   (max_len_ff),
      .step      (step),
      .status    (status)
   );

   // result register
   always_comb begin
      if (req_fire) begin
         rsp_valid_in = step.emit;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && step.emit) begin
         rsp_ff <= step;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.result_kind    = rsp_ff.kind;
   assign rsp_bus.payload_byte   = rsp_ff.payload_byte;
   assign rsp_bus.frame_opcode   = rsp_ff.opcode;
   assign rsp_bus.final_fragment = rsp_ff.fin;
   assign rsp_bus.last_of_frame  = rsp_ff.last;
   assign rsp_bus.frame_action   = rsp_ff.action;

   // checks
   `WSFD_ASSERT_NEXT(a_err_sticky, clock, reset, status.err_latched, status.err_latched, "error flag cleared without reset")
   `WSFD_ASSERT_NOW(a_silent_after_err, clock, reset, status.err_latched, !step.emit, "result produced after a protocol error")
   `WSFD_ASSERT_NOW(a_result_from_transfer, clock, reset, $rose(rsp_valid_ff), $past(req_fire), "result appeared without an input transfer")
   `WSFD_ASSERT_NOW(a_empty_is_last, clock, reset, rsp_valid_ff && rsp_ff.kind == wsfd_pkg::KIND_EMPTY, rsp_ff.last, "empty-frame result not marked last")
   `WSFD_ASSERT_NOW(a_error_not_last, clock, reset, rsp_valid_ff && rsp_ff.kind == wsfd_pkg::KIND_ERROR, !rsp_ff.last && rsp_ff.action == wsfd_pkg::ACT_DELIVER, "error result carries frame end")

endmodule

>>> tb/tb_websocket_frame_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer_core
// Feeds client frame byte streams into the deframer and checks every result
// against a cycle-free frame parser model kept in the bench: a short table of
// hand-built frames first, then random well-formed frames under several
// maximum lengths and idle patterns, and one broken frame at the very end,
// since the error is sticky until reset.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer_core;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SHOWN_MISMATCHES = 10;
   localparam int DRAIN_CYCLES = 4;

   // header byte fields
   localparam logic [3:0] HDR_FIN_NIBBLE   = 4'h8;
   localparam logic [3:0] HDR_NOFIN_NIBBLE = 4'h0;
   localparam logic [2:0] RSV_CLEAR        = 3'b000;
   localparam logic [6:0] LEN7_EXT64       = 7'd127;

   localparam logic [3:0] FRAME_OPS [6] =
      '{wsfd_pkg::OP_CONT, wsfd_pkg::OP_TEXT, wsfd_pkg::OP_BINARY,
        wsfd_pkg::OP_CLOSE, wsfd_pkg::OP_PING, wsfd_pkg::OP_PONG};

   typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_type;

   typedef enum int {
      BREAK_RSV, BREAK_OPCODE, BREAK_CONTROL_FRAG,
      BREAK_MASK_CLEAR, BREAK_LONG_EXT, BREAK_LONG_SHORT
   } break_kind_type;

   typedef struct packed {
      wsfd_pkg::kind_type kind;
      logic [7:0]         payload;
      logic [3:0]         opcode;
      logic               fin;
      logic               last;
      logic [1:0]         action;
   } deframed_type;

   typedef struct packed {
      logic [7:0] data;
      logic       typed;
   } dir_row_type;

   // empty close frame, two-byte text fragment, one-byte binary frame with 16-bit length
   localparam dir_row_type DIRECTED_ROWS [23] = '{
      '{8'h88, 1'b0}, '{8'h80, 1'b0},
      '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b1},
      '{8'h01, 1'b0}, '{8'h82, 1'b0},
      '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b0},
      '{8'h00, 1'b1}, '{8'hFF, 1'b1},
      '{8'h82, 1'b0}, '{8'hFE, 1'b0}, '{8'h00, 1'b0}, '{8'h01, 1'b0},
      '{8'hA5, 1'b0}, '{8'h5A, 1'b0}, '{8'h3C, 1'b0}, '{8'hC3, 1'b0},
      '{8'h7E, 1'b0}
   };

   localparam deframed_type DIRECTED_RESULTS [3] = '{
      '{wsfd_pkg::KIND_EMPTY, 8'h00, wsfd_pkg::OP_CLOSE, 1'b1, 1'b1, wsfd_pkg::ACT_CLOSE},
      '{wsfd_pkg::KIND_DATA,  8'hFF, wsfd_pkg::OP_TEXT,  1'b0, 1'b0, wsfd_pkg::ACT_DELIVER},
      '{wsfd_pkg::KIND_DATA,  8'h00, wsfd_pkg::OP_TEXT,  1'b0, 1'b1, wsfd_pkg::ACT_IGNORE}
   };

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [wsfd_pkg::LEN_REG_BITS-1:0] csr_wr_data;

   wsfd_req_if req_bus ();
   wsfd_rsp_if rsp_bus ();

   websocket_frame_deframer_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // frame parser model state
   wsfd_pkg::phase_type fp_phase;
   logic                fp_fin;
   logic [3:0]          fp_opcode;
   logic [3:0]          fp_left;
   logic [63:0]         fp_length;
   logic [63:0]         fp_position;
   logic [7:0]          fp_key [4];
   logic                fp_error;
   logic [31:0]         fp_max;

   deframed_type deframed_q [$];
   int           mismatch_count;
   int unsigned  cycle_count;
   int unsigned  bytes_sent;
   int           src_idle_pct;
   int           sink_stall_pct;

   always #10 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // result sink stalls
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
   end

   function automatic logic [1:0] action_for_frame();
      if (fp_fin) begin
         if (fp_opcode == wsfd_pkg::OP_TEXT || fp_opcode == wsfd_pkg::OP_BINARY)
            return wsfd_pkg::ACT_DELIVER;
         if (fp_opcode == wsfd_pkg::OP_CLOSE) return wsfd_pkg::ACT_CLOSE;
      end
      return wsfd_pkg::ACT_IGNORE;
   endfunction

   // one byte through the parser model
   task automatic deframe_byte(input logic [7:0] b, output bit produced, output deframed_type r);
      logic       bad;
      logic [3:0] op;
      logic [1:0] key_idx;
      logic [7:0] plain;
      bad = 1'b0;
      produced = 1'b0;
      r = '0;
      if (fp_error) return;
      case (fp_phase)
         wsfd_pkg::PH_HDR1: begin
            op = b[3:0];
            fp_opcode = op;
            if (b[7:4] == HDR_FIN_NIBBLE) fp_fin = 1'b1;
            else if (b[7:4] == HDR_NOFIN_NIBBLE) fp_fin = 1'b0;
            else bad = 1'b1;
            if (!bad && !(op <= wsfd_pkg::OP_BINARY || op == wsfd_pkg::OP_CLOSE ||
                          op == wsfd_pkg::OP_PING || op == wsfd_pkg::OP_PONG))
               bad = 1'b1;
            // fragmented control frame
            if (!bad && !fp_fin && op >= wsfd_pkg::OP_CLOSE) bad = 1'b1;
            if (!bad) fp_phase = wsfd_pkg::PH_HDR2;
         end
         wsfd_pkg::PH_HDR2: begin
            if (!b[7]) begin
               bad = 1'b1;
            end else begin
               fp_length = '0;
               if (b[6:0] <= wsfd_pkg::LEN7_MAX) begin
                  fp_length = 64'(b[6:0]);
                  if (fp_length > fp_max) begin
                     bad = 1'b1;
                  end else begin
                     fp_left = wsfd_pkg::MASK_BYTES;
                     fp_phase = wsfd_pkg::PH_MASK;
                  end
               end else begin
                  fp_left = (b[6:0] == wsfd_pkg::LEN7_EXT16) ?
                            wsfd_pkg::EXT16_BYTES : wsfd_pkg::EXT64_BYTES;
                  fp_phase = wsfd_pkg::PH_EXTLEN;
               end
            end
         end
         wsfd_pkg::PH_EXTLEN: begin
            fp_length = {fp_length[55:0], b};
            fp_left = fp_left - 4'd1;
            if (fp_left == 4'd0) begin
               if (fp_length > fp_max) begin
                  bad = 1'b1;
               end else begin
                  fp_left = wsfd_pkg::MASK_BYTES;
                  fp_phase = wsfd_pkg::PH_MASK;
               end
            end
         end
         wsfd_pkg::PH_MASK: begin
            key_idx = 2'd0 - fp_left[1:0];
            fp_key[key_idx] = b;
            fp_left = fp_left - 4'd1;
            if (fp_left == 4'd0) begin
               fp_position = '0;
               if (fp_length == '0) begin
                  fp_phase = wsfd_pkg::PH_HDR1;
                  produced = 1'b1;
                  r = '{wsfd_pkg::KIND_EMPTY, 8'h00, fp_opcode, fp_fin, 1'b1,
                        action_for_frame()};
               end else begin
                  fp_phase = wsfd_pkg::PH_PAYLOAD;
               end
            end
         end
         wsfd_pkg::PH_PAYLOAD: begin
            plain = b ^ fp_key[fp_position[1:0]];
            fp_position = fp_position + 64'd1;
            produced = 1'b1;
            if (fp_position >= fp_length) begin
               fp_phase = wsfd_pkg::PH_HDR1;
               r = '{wsfd_pkg::KIND_DATA, plain, fp_opcode, fp_fin, 1'b1, action_for_frame()};
            end else begin
               r = '{wsfd_pkg::KIND_DATA, plain, fp_opcode, fp_fin, 1'b0,
                     wsfd_pkg::ACT_DELIVER};
            end
         end
         default: fp_phase = wsfd_pkg::PH_HDR1;
      endcase
      // sticky error, reported once
      if (bad) begin
         fp_error = 1'b1;
         produced = 1'b1;
         r = '{wsfd_pkg::KIND_ERROR, 8'h00, fp_opcode, fp_fin, 1'b0, wsfd_pkg::ACT_DELIVER};
      end
   endtask

   // one byte transfer with random sender gaps
   task automatic drive_byte(input logic [7:0] b, input bit typed,
                             input deframed_type typed_res);
      bit           produced;
      deframed_type res;
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      deframe_byte(b, produced, res);
      if (typed) begin
         res = typed_res;
         produced = 1'b1;
      end
      if (produced) deframed_q.push_back(res);
      bytes_sent++;
   endtask

   // stop sending and wait for every pending result, plus the output latency
   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (deframed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_length(input logic [31:0] value);
      drain_results();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      fp_max = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_frame(input logic fin, input logic [3:0] op, input logic [63:0] len,
                             input len_form_type form);
      logic [7:0] frame_bytes [$];
      int         roll;
      frame_bytes.push_back({fin, RSV_CLEAR, op});
      case (form)
         LEN_SHORT: frame_bytes.push_back({1'b1, len[6:0]});
         LEN_EXT16: begin
            frame_bytes.push_back({1'b1, wsfd_pkg::LEN7_EXT16});
            frame_bytes.push_back(len[15:8]);
            frame_bytes.push_back(len[7:0]);
         end
         default: begin
            frame_bytes.push_back({1'b1, LEN7_EXT64});
            for (int i = 7; i >= 0; i--) frame_bytes.push_back(len[i*8 +: 8]);
         end
      endcase
      // mask key, now and then all zeros or all ones
      roll = $urandom_range(9);
      for (int k = 0; k < 4; k++) begin
         if (roll == 0) frame_bytes.push_back(8'h00);
         else if (roll == 1) frame_bytes.push_back(8'hFF);
         else frame_bytes.push_back(8'($urandom_range(255)));
      end
      for (longint unsigned i = 0; i < len; i++)
         frame_bytes.push_back(8'($urandom_range(255)));
      foreach (frame_bytes[i]) drive_byte(frame_bytes[i], 1'b0, '0);
   endtask

   function automatic logic [63:0] pick_length(input logic [31:0] cap);
      int unsigned roll;
      int unsigned n;
      roll = $urandom_range(99);
      if (roll < 15) n = 0;
      else if (roll < 35) n = (cap <= 64) ? cap : $urandom_range(8, 1);
      else if (roll < 75) n = $urandom_range(8, 1);
      else if (roll < 93) n = $urandom_range(40, 9);
      else n = $urandom_range(300, 126);
      if (n > cap) n = cap;
      return 64'(n);
   endfunction

   task automatic run_random_frames(input int unsigned budget);
      int unsigned  stop_at;
      logic [31:0]  cap;
      logic         fin;
      logic [3:0]   op;
      logic [63:0]  len;
      int unsigned  roll;
      len_form_type form;
      stop_at = bytes_sent + budget;
      cap = (fp_max > 300) ? 32'd300 : fp_max;
      while (bytes_sent < stop_at) begin
         fin = 1'($urandom_range(1));
         op = fin ? FRAME_OPS[$urandom_range(5)] : FRAME_OPS[$urandom_range(2)];
         len = pick_length(cap);
         roll = $urandom_range(99);
         if (len <= wsfd_pkg::LEN7_MAX)
            form = (roll < 70) ? LEN_SHORT : (roll < 85) ? LEN_EXT16 : LEN_EXT64;
         else
            form = (roll < 50) ? LEN_EXT16 : LEN_EXT64;
         send_frame(fin, op, len, form);
      end
   endtask

   // one protocol violation of a random kind, then bytes the block must ignore
   task automatic send_broken_frame();
      break_kind_type flaw;
      logic           fin;
      logic [3:0]     op;
      logic [31:0]    short_max;
      flaw = break_kind_type'($urandom_range(5));
      fin = 1'($urandom_range(1));
      op = FRAME_OPS[$urandom_range(5)];
      case (flaw)
         BREAK_RSV:
            drive_byte({fin, 3'($urandom_range(7, 1)), op}, 1'b0, '0);
         BREAK_OPCODE: begin
            op = $urandom_range(1) ? 4'($urandom_range(7, 3)) : 4'($urandom_range(15, 11));
            drive_byte({fin, RSV_CLEAR, op}, 1'b0, '0);
         end
         BREAK_CONTROL_FRAG:
            drive_byte({1'b0, RSV_CLEAR, FRAME_OPS[$urandom_range(5, 3)]}, 1'b0, '0);
         BREAK_MASK_CLEAR: begin
            drive_byte({1'b1, RSV_CLEAR, op}, 1'b0, '0);
            drive_byte({1'b0, 7'($urandom_range(127))}, 1'b0, '0);
         end
         BREAK_LONG_EXT: begin
            drive_byte({1'b1, RSV_CLEAR, op}, 1'b0, '0);
            drive_byte({1'b1, LEN7_EXT64}, 1'b0, '0);
            drive_byte(8'($urandom_range(255, 1)), 1'b0, '0);
            repeat (7) drive_byte(8'($urandom_range(255)), 1'b0, '0);
         end
         default: begin
            short_max = $urandom_range(124, 0);
            write_max_length(short_max);
            drive_byte({1'b1, RSV_CLEAR, op}, 1'b0, '0);
            drive_byte({1'b1, 7'($urandom_range(125, short_max + 1))}, 1'b0, '0);
         end
      endcase
      repeat (12) drive_byte(8'($urandom_range(255)), 1'b0, '0);
   endtask

   // result checker
   always @(posedge clock) begin : check_results
      deframed_type got;
      deframed_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{wsfd_pkg::kind_type'(rsp_bus.result_kind), rsp_bus.payload_byte,
                 rsp_bus.frame_opcode, rsp_bus.final_fragment, rsp_bus.last_of_frame,
                 rsp_bus.frame_action};
         if (deframed_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_MISMATCHES)
               $display("cycle %0d: unexpected result kind %0d byte %02h op %0h fin %0b last %0b act %0d",
                        cycle_count, got.kind, got.payload, got.opcode, got.fin, got.last,
                        got.action);
         end else begin
            want = deframed_q.pop_front();
            if (got.kind !== want.kind || got.payload !== want.payload ||
                got.opcode !== want.opcode || got.fin !== want.fin ||
                got.last !== want.last || got.action !== want.action) begin
               mismatch_count++;
               if (mismatch_count <= SHOWN_MISMATCHES) begin
                  $display("cycle %0d: expected kind %0d byte %02h op %0h fin %0b last %0b act %0d",
                           cycle_count, want.kind, want.payload, want.opcode, want.fin,
                           want.last, want.action);
                  $display("cycle %0d:      got kind %0d byte %02h op %0h fin %0b last %0b act %0d",
                           cycle_count, got.kind, got.payload, got.opcode, got.fin, got.last,
                           got.action);
               end
            end
         end
      end
   end

   // stimulus sequence
   initial begin : stimulus
      int typed_idx;
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      rsp_bus.ready = 1'b0;
      mismatch_count = 0;
      cycle_count = 0;
      bytes_sent = 0;
      src_idle_pct = 26;
      sink_stall_pct = 78;
      typed_idx = 0;

      // parser model after reset
      fp_phase = wsfd_pkg::PH_HDR1;
      fp_fin = 1'b0;
      fp_opcode = '0;
      fp_left = '0;
      fp_length = '0;
      fp_position = '0;
      foreach (fp_key[i]) fp_key[i] = '0;
      fp_error = 1'b0;
      fp_max = wsfd_pkg::MAX_LEN_RESET;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // hand-built frames at the reset maximum
      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].typed) begin
            drive_byte(DIRECTED_ROWS[i].data, 1'b1, DIRECTED_RESULTS[typed_idx]);
            typed_idx++;
         end else begin
            drive_byte(DIRECTED_ROWS[i].data, 1'b0, '0);
         end
      end

      write_max_length(32'hFFFF_FFFF);
      run_random_frames(320);

      src_idle_pct = 78;
      sink_stall_pct = 26;
      // only empty frames pass
      write_max_length(32'd0);
      run_random_frames(60);
      write_max_length($urandom_range(40, 1));
      run_random_frames(250);

      src_idle_pct = 0;
      sink_stall_pct = 0;
      write_max_length($urandom_range(2000, 300));
      run_random_frames(300);

      send_broken_frame();
      drain_results();
      repeat (2 * DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && deframed_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
